### hdl/gf5dp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf5dp_pkg
// Shared types and constants for the GF(2^8) five-parity dot product block.
// ----------------------------------------------------------------------------
package gf5dp_pkg;

  localparam int PARITY_COUNT = 5;
  localparam int MAX_SOURCES  = 32;
  localparam int LANE_W       = 8;
  localparam int SRC_W        = 5;
  localparam int NIB_W        = 4;
  localparam int ROW_W        = SRC_W + NIB_W;
  localparam int ROWS         = 1 << ROW_W;
  localparam int CNT_W        = 6;
  localparam int PSEL_W       = 3;
  localparam int ENTRY_W      = 5;

  // One table row: one byte lane for each of the five parities
  typedef logic [PARITY_COUNT-1:0][LANE_W-1:0] lanes_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } op_e;

  // Control of the lookup stage, one data byte per transaction
  typedef struct packed {
    logic valid;
    logic last;
  } lookup_ctrl_t;

endpackage

`default_nettype wire

### hdl/gf5dp_tbl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf5dp_tbl_ram
// One half of the product tables: one row per (source, nibble), one byte
// lane per parity. Lane write enables, registered read.
// ----------------------------------------------------------------------------
module gf5dp_tbl_ram
  import gf5dp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic [PARITY_COUNT-1:0] we_i,
  input  wire logic [ROW_W-1:0]        waddr_i,
  input  wire logic [LANE_W-1:0]       wdata_i,
  input  wire logic                    re_i,
  input  wire logic [ROW_W-1:0]        raddr_i,
  output lanes_t                       rdata_o
);

  lanes_t mem [ROWS];
  lanes_t rdata_q;

  // Byte-lane writes
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < PARITY_COUNT; p++) begin
      if (we_i[p]) begin
        mem[waddr_i][p] <= wdata_i;
      end
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/gf5dp_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf5dp_accum
// Combines the low and high nibble products into the five parity
// accumulators and holds the finished column in the output register.
// ----------------------------------------------------------------------------
module gf5dp_accum
  import gf5dp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire lookup_ctrl_t ctrl_i,
  input  wire lanes_t       lo_prod_i,
  input  wire lanes_t       hi_prod_i,
  output logic              stall_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output lanes_t            parity_o
);

  lanes_t acc_q, acc_d;
  lanes_t out_q, out_d;
  logic   out_valid_q, out_valid_d;
  logic   advance;
  lanes_t acc_new;

  // Column end waits while the previous result is still pending
  assign stall_o = ctrl_i.valid && ctrl_i.last && out_valid_q && !out_ready_i;
  assign advance = ctrl_i.valid && !stall_o;

  always_comb begin
    for (int p = 0; p < PARITY_COUNT; p++) begin
      acc_new[p] = acc_q[p] ^ lo_prod_i[p] ^ hi_prod_i[p];
    end
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance) begin
      if (ctrl_i.last) begin
        acc_d       = '0;
        out_d       = acc_new;
        out_valid_d = 1'b1;
      end else begin
        acc_d = acc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign parity_o    = out_q;

  // A finished column leaves the accumulators clear
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ctrl_i.last |=> acc_q == '0)
    else $error("accumulators not cleared after column end");

  // A new result only comes from a column end
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && ctrl_i.last))
    else $error("result raised without a column end");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && out_q == $past(out_q))
    else $error("pending result lost");

endmodule

`default_nettype wire

### hdl/gf256_five_parity_dot_product.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: the edge that accepts a column's last source byte reads the tables into
//   their read registers; the accumulator stage then registers the finished result.
// Throughput: one transaction (load or data) per cycle while not stalled; a column end
//   waits only while the previous result is still unaccepted, and holds off all input.
// Reset: counter, accumulators and handshakes cleared, source_count = 1;
//   product tables hold no defined value until loaded.
// ----------------------------------------------------------------------------
// gf256_five_parity_dot_product
// Erasure-code parity generator over GF(2^8) with split-nibble product tables.
// ----------------------------------------------------------------------------
module gf256_five_parity_dot_product
  import gf5dp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CNT_W-1:0]   source_count_i,
  // input items
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               operation_i,
  input  wire logic [PSEL_W-1:0]  parity_select_i,
  input  wire logic [SRC_W-1:0]   source_select_i,
  input  wire logic [ENTRY_W-1:0] table_entry_i,
  input  wire logic [LANE_W-1:0]  value_i,
  // results
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [LANE_W-1:0]       parity_zero_o,
  output logic [LANE_W-1:0]       parity_one_o,
  output logic [LANE_W-1:0]       parity_two_o,
  output logic [LANE_W-1:0]       parity_three_o,
  output logic [LANE_W-1:0]       parity_four_o
);

  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        eff_count;
  logic [SRC_W-1:0]        src_cnt_q, src_cnt_d;
  logic                    accept, is_load, is_data, last;
  logic [PARITY_COUNT-1:0] lane_we, lo_we, hi_we;
  logic [ROW_W-1:0]        waddr, lo_raddr, hi_raddr;
  lookup_ctrl_t            ctrl_q, ctrl_d;
  lanes_t                  lo_prod, hi_prod, parity;
  logic                    stall;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
    end else if (cfg_valid_i) begin
      count_q <= source_count_i;
    end
  end

  // Clamp the count to 1..MAX_SOURCES
  always_comb begin
    if (count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (count_q > CNT_W'(MAX_SOURCES)) begin
      eff_count = CNT_W'(MAX_SOURCES);
    end else begin
      eff_count = count_q;
    end
  end

  // Input decode
  assign in_ready_o = !stall;
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = accept && (op_e'(operation_i) == OP_LOAD);
  assign is_data    = accept && (op_e'(operation_i) == OP_DATA);
  assign last       = ({1'b0, src_cnt_q} + CNT_W'(1)) >= eff_count;

  // Lane enables; parity selects beyond the last parity write nothing
  always_comb begin
    for (int p = 0; p < PARITY_COUNT; p++) begin
      lane_we[p] = is_load && (parity_select_i == PSEL_W'(p));
    end
  end

  assign lo_we    = table_entry_i[ENTRY_W-1] ? '0 : lane_we;
  assign hi_we    = table_entry_i[ENTRY_W-1] ? lane_we : '0;
  assign waddr    = {source_select_i, table_entry_i[NIB_W-1:0]};
  assign lo_raddr = {src_cnt_q, value_i[NIB_W-1:0]};
  assign hi_raddr = {src_cnt_q, value_i[LANE_W-1:NIB_W]};

  // Source counter
  always_comb begin
    src_cnt_d = src_cnt_q;
    if (is_data) begin
      src_cnt_d = last ? '0 : src_cnt_q + SRC_W'(1);
    end
  end

  // Lookup stage control, held while the column end stalls
  always_comb begin
    ctrl_d = ctrl_q;
    if (!stall) begin
      ctrl_d.valid = is_data;
      ctrl_d.last  = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cnt_q <= '0;
      ctrl_q    <= '0;
    end else begin
      src_cnt_q <= src_cnt_d;
      ctrl_q    <= ctrl_d;
    end
  end

  // Low nibble products
  gf5dp_tbl_ram u_lo_ram (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (is_data),
    .raddr_i (lo_raddr),
    .rdata_o (lo_prod)
  );

  // High nibble products
  gf5dp_tbl_ram u_hi_ram (
    .clk_i   (clk_i),
    .we_i    (hi_we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (is_data),
    .raddr_i (hi_raddr),
    .rdata_o (hi_prod)
  );

  gf5dp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_q),
    .lo_prod_i   (lo_prod),
    .hi_prod_i   (hi_prod),
    .stall_o     (stall),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .parity_o    (parity)
  );

  assign parity_zero_o  = parity[0];
  assign parity_one_o   = parity[1];
  assign parity_two_o   = parity[2];
  assign parity_three_o = parity[3];
  assign parity_four_o  = parity[4];

  // Column end restarts the counter
  a_cnt_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_data && last |=> src_cnt_q == '0)
    else $error("source counter not restarted at column end");

  // Every accepted data byte reaches the lookup stage
  a_data_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_data |=> ctrl_q.valid)
    else $error("data byte dropped before lookup");

  // Loads leave the column untouched
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |=> src_cnt_q == $past(src_cnt_q) && !ctrl_q.valid)
    else $error("load disturbed the column");

endmodule

`default_nettype wire
